// ===== rtl/core/sbpe_pkg.sv =====
// Shared types and constants of the stereo biquad equalizer.
package sbpe_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_FRAC_BITS = 27;
  localparam int NUM_CHANNELS   = 2;
  localparam int COEF_BITS      = 32;
  localparam int NUM_COEFS      = 5;

  localparam int CFG_IDX_BITS = $clog2(NUM_COEFS);
  localparam int CH_IDX_BITS  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int PROD_BITS    = COEF_BITS + SAMPLE_BITS;
  // five products plus rounding bias never wrap with three guard bits
  localparam int ACC_BITS     = PROD_BITS + 3;

  // queue depths are powers of two so pointers wrap on their own
  localparam int FRONT_DEPTH = 2;
  localparam int OUT_DEPTH   = 2;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;
  typedef logic signed [PROD_BITS-1:0]   prod_t;
  typedef logic signed [ACC_BITS-1:0]    acc_t;
  typedef logic [CH_IDX_BITS-1:0]        ch_idx_t;
  typedef logic [CFG_IDX_BITS-1:0]       cfg_idx_t;

  localparam cfg_idx_t REG_COEF_B0 = CFG_IDX_BITS'(0);
  localparam cfg_idx_t REG_COEF_B1 = CFG_IDX_BITS'(1);
  localparam cfg_idx_t REG_COEF_B2 = CFG_IDX_BITS'(2);
  localparam cfg_idx_t REG_COEF_A1 = CFG_IDX_BITS'(3);
  localparam cfg_idx_t REG_COEF_A2 = CFG_IDX_BITS'(4);

  localparam coef_t   COEF_ONE   = coef_t'(COEF_BITS'(1) << COEF_FRAC_BITS);
  localparam acc_t    ROUND_BIAS = acc_t'(ACC_BITS'(1) << (COEF_FRAC_BITS - 1));
  localparam sample_t SAMPLE_MAX = sample_t'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
  localparam sample_t SAMPLE_MIN = sample_t'({1'b1, {(SAMPLE_BITS-1){1'b0}}});

  typedef struct packed {
    logic    channel;
    sample_t sample_in;
  } in_word_t;

  typedef struct packed {
    logic    channel_out;
    sample_t sample_out;
    logic    clipped;
  } out_word_t;

  typedef struct packed {
    coef_t b0;
    coef_t b1;
    coef_t b2;
    coef_t a1;
    coef_t a2;
  } coef_set_t;

  // one classified sample waiting for the filter engine
  typedef struct packed {
    logic    channel;
    ch_idx_t hist_idx;
    sample_t sample;
  } job_t;

endpackage

// ===== rtl/core/sbpe_coefs.sv =====
// Coefficient register bank written through the configuration port.
module sbpe_coefs (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  sbpe_pkg::cfg_idx_t   cfg_index,
  input  sbpe_pkg::coef_t      cfg_data,
  output sbpe_pkg::coef_set_t  coefs
);
  import sbpe_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      coefs.b0 <= COEF_ONE;
      coefs.b1 <= '0;
      coefs.b2 <= '0;
      coefs.a1 <= '0;
      coefs.a2 <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_COEF_B0: coefs.b0 <= cfg_data;
        REG_COEF_B1: coefs.b1 <= cfg_data;
        REG_COEF_B2: coefs.b2 <= cfg_data;
        REG_COEF_A1: coefs.a1 <= cfg_data;
        REG_COEF_A2: coefs.a2 <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/sbpe_front.sv =====
// Input side: accept words, map the channel to a history slot, queue them.
module sbpe_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  sbpe_pkg::in_word_t in_word,
  output logic               job_valid,
  output sbpe_pkg::job_t     job_head,
  input  logic               job_take
);
  import sbpe_pkg::*;

  localparam int PTR_BITS = (FRONT_DEPTH > 1) ? $clog2(FRONT_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(FRONT_DEPTH + 1);

  job_t                 mem [FRONT_DEPTH];
  logic [PTR_BITS-1:0]  wr_ptr;
  logic [PTR_BITS-1:0]  rd_ptr;
  logic [CNT_BITS-1:0]  count;
  logic [CNT_BITS-1:0]  count_next;
  logic                 do_push;
  logic                 do_take;
  job_t                 new_job;

  assign full      = (count == CNT_BITS'(FRONT_DEPTH));
  assign job_valid = (count != '0);
  assign job_head  = mem[rd_ptr];
  assign do_push   = push && !full;
  assign do_take   = job_take && job_valid;

  // channels beyond the last one share the last channel's history
  always_comb begin
    new_job.channel = in_word.channel;
    new_job.sample  = in_word.sample_in;
    if (int'(in_word.channel) >= NUM_CHANNELS) begin
      new_job.hist_idx = CH_IDX_BITS'(NUM_CHANNELS - 1);
    end else begin
      new_job.hist_idx = CH_IDX_BITS'(in_word.channel);
    end
  end

  always_comb begin
    unique case ({do_push, do_take})
      2'b10:   count_next = count + CNT_BITS'(1);
      2'b01:   count_next = count - CNT_BITS'(1);
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (do_push) begin
        wr_ptr <= wr_ptr + PTR_BITS'(1);
      end
      if (do_take) begin
        rd_ptr <= rd_ptr + PTR_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= new_job;
    end
  end

endmodule

// ===== rtl/core/sbpe_back.sv =====
// Filter engine: two-multiplier MAC sequence, per-channel history, result queue.
module sbpe_back (
  input  logic                clk,
  input  logic                rst,
  input  sbpe_pkg::coef_set_t coefs,
  input  logic                job_valid,
  input  sbpe_pkg::job_t      job_head,
  output logic                job_take,
  output logic                empty,
  input  logic                pop,
  output sbpe_pkg::out_word_t out_word
);
  import sbpe_pkg::*;

  localparam int PTR_BITS = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(OUT_DEPTH + 1);
  localparam int YF_BITS  = ACC_BITS - COEF_FRAC_BITS;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_MUL0   = 5'b00010,
    ST_MUL1   = 5'b00100,
    ST_MUL2   = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  job_t   cur;

  sample_t x1_hist [NUM_CHANNELS];
  sample_t x2_hist [NUM_CHANNELS];
  sample_t y1_hist [NUM_CHANNELS];
  sample_t y2_hist [NUM_CHANNELS];

  coef_t   op_a_coef;
  coef_t   op_b_coef;
  sample_t op_a_data;
  sample_t op_b_data;
  logic    neg_a;
  logic    neg_b;
  prod_t   prod_a;
  prod_t   prod_b;
  logic    neg_a_q;
  logic    neg_b_q;

  acc_t    acc;
  acc_t    acc_base;
  acc_t    term_a;
  acc_t    term_b;
  acc_t    acc_sum;

  logic signed [YF_BITS-1:0]        y_full;
  logic [YF_BITS-SAMPLE_BITS:0]     y_top;
  logic                             clip;
  sample_t                          y_sat;

  out_word_t            out_mem [OUT_DEPTH];
  logic [PTR_BITS-1:0]  out_wr_ptr;
  logic [PTR_BITS-1:0]  out_rd_ptr;
  logic [CNT_BITS-1:0]  out_count;
  logic [CNT_BITS-1:0]  out_count_next;
  logic                 res_push;
  logic                 res_pop;
  logic                 can_start;

  // operand selection: up to two products per pass, feedback terms subtracted
  always_comb begin
    op_a_coef = '0;
    op_a_data = '0;
    op_b_coef = '0;
    op_b_data = '0;
    neg_a     = 1'b0;
    neg_b     = 1'b0;
    unique case (state)
      ST_MUL0: begin
        op_a_coef = coefs.b0;
        op_a_data = cur.sample;
        op_b_coef = coefs.b1;
        op_b_data = x1_hist[cur.hist_idx];
      end
      ST_MUL1: begin
        op_a_coef = coefs.b2;
        op_a_data = x2_hist[cur.hist_idx];
        op_b_coef = coefs.a1;
        op_b_data = y1_hist[cur.hist_idx];
        neg_b     = 1'b1;
      end
      ST_MUL2: begin
        op_a_coef = coefs.a2;
        op_a_data = y2_hist[cur.hist_idx];
        neg_a     = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_a  <= op_a_coef * op_a_data;
    prod_b  <= op_b_coef * op_b_data;
    neg_a_q <= neg_a;
    neg_b_q <= neg_b;
  end

  // accumulate one product pair per cycle; the first pass seeds the rounding bias
  always_comb begin
    term_a   = neg_a_q ? -acc_t'(prod_a) : acc_t'(prod_a);
    term_b   = neg_b_q ? -acc_t'(prod_b) : acc_t'(prod_b);
    acc_base = (state == ST_MUL1) ? ROUND_BIAS : acc;
    acc_sum  = acc_base + term_a + term_b;
  end

  always_ff @(posedge clk) begin
    if (state == ST_MUL1 || state == ST_MUL2) begin
      acc <= acc_sum;
    end
  end

  // scale, then saturate when the high bits are not all copies of the sign
  always_comb begin
    y_full = acc_sum[ACC_BITS-1:COEF_FRAC_BITS];
    y_top  = y_full[YF_BITS-1:SAMPLE_BITS-1];
    clip   = !((&y_top) || !(|y_top));
    if (clip) begin
      y_sat = y_full[YF_BITS-1] ? SAMPLE_MIN : SAMPLE_MAX;
    end else begin
      y_sat = y_full[SAMPLE_BITS-1:0];
    end
  end

  // result queue
  assign res_push = (state == ST_FINISH);
  assign empty    = (out_count == '0);
  assign res_pop  = pop && !empty;
  assign out_word = out_mem[out_rd_ptr];

  always_comb begin
    unique case ({res_push, res_pop})
      2'b10:   out_count_next = out_count + CNT_BITS'(1);
      2'b01:   out_count_next = out_count - CNT_BITS'(1);
      default: out_count_next = out_count;
    endcase
  end

  // start only when the result will find a slot; nothing else is in flight then
  assign can_start = (state == ST_IDLE || state == ST_FINISH) &&
                     (out_count_next < CNT_BITS'(OUT_DEPTH));
  assign job_take  = job_valid && can_start;

  always_comb begin
    unique case (state)
      ST_IDLE:   state_next = job_take ? ST_MUL0 : ST_IDLE;
      ST_MUL0:   state_next = ST_MUL1;
      ST_MUL1:   state_next = ST_MUL2;
      ST_MUL2:   state_next = ST_FINISH;
      ST_FINISH: state_next = job_take ? ST_MUL0 : ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_wr_ptr <= '0;
      out_rd_ptr <= '0;
      out_count  <= '0;
    end else begin
      state     <= state_next;
      out_count <= out_count_next;
      if (res_push) begin
        out_wr_ptr <= out_wr_ptr + PTR_BITS'(1);
      end
      if (res_pop) begin
        out_rd_ptr <= out_rd_ptr + PTR_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      cur <= job_head;
    end
    if (res_push) begin
      out_mem[out_wr_ptr] <= '{channel_out: cur.channel, sample_out: y_sat, clipped: clip};
    end
  end

  // history shifts once per sample, holding the saturated output
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        x1_hist[i] <= '0;
        x2_hist[i] <= '0;
        y1_hist[i] <= '0;
        y2_hist[i] <= '0;
      end
    end else if (res_push) begin
      x2_hist[cur.hist_idx] <= x1_hist[cur.hist_idx];
      x1_hist[cur.hist_idx] <= cur.sample;
      y2_hist[cur.hist_idx] <= y1_hist[cur.hist_idx];
      y1_hist[cur.hist_idx] <= y_sat;
    end
  end

`ifndef SYNTHESIS
  a_out_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (out_count < CNT_BITS'(OUT_DEPTH)))
    else $error("result queue has no room at finish");

  a_take_when_free: assert property (@(posedge clk) disable iff (rst)
    job_take |-> (job_valid && (state == ST_IDLE || state == ST_FINISH)))
    else $error("job taken while engine busy");

  a_mul_to_finish: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL2) |=> (state == ST_FINISH))
    else $error("multiply sequence broken");

  a_hist_written: assert property (@(posedge clk) disable iff (rst)
    res_push |=> (x1_hist[$past(cur.hist_idx)] == $past(cur.sample)))
    else $error("input history not updated");
`endif

endmodule

// ===== rtl/core/stereo_biquad_peaking_eq.sv =====
// Top level of the stereo biquad peaking equalizer (direct form I).
//
//  channel   | direction | handshake              | word
//  ----------+-----------+------------------------+-------------------------------
//  input     | in        | push / full            | in_word: channel, sample_in
//  result    | out       | pop / empty            | out_word: channel_out,
//            |           |                        |   sample_out, clipped
//  config    | in        | cfg_write (no wait)    | cfg_index, cfg_data
//
//  Each word goes through the filter engine as three passes through a pair of
//  32x24 multipliers, then a finish step that rounds, saturates and writes history.
//  The next word can start in the finish step of the last one; with both queues
//  empty the result comes out after the input queue, the passes and the finish.
//  Synchronous active-high reset clears the queues, the history and loads
//  b0 = 1.0 with all other coefficients zero.
//  A two-word input queue and a two-word result queue let either side stall
//  on its own; the engine starts a word only when its result has a slot.
module stereo_biquad_peaking_eq (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  sbpe_pkg::in_word_t  in_word,
  output logic                empty,
  input  logic                pop,
  output sbpe_pkg::out_word_t out_word,
  input  logic                cfg_write,
  input  sbpe_pkg::cfg_idx_t  cfg_index,
  input  sbpe_pkg::coef_t     cfg_data
);
  import sbpe_pkg::*;

  coef_set_t coefs;
  logic      job_valid;
  job_t      job_head;
  logic      job_take;

  // hold the five Q4.27 coefficients
  sbpe_coefs u_coefs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coefs     (coefs)
  );

  // accept words, map channel to history slot, queue
  sbpe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_word   (in_word),
    .job_valid (job_valid),
    .job_head  (job_head),
    .job_take  (job_take)
  );

  // run the biquad and queue results
  sbpe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .coefs     (coefs),
    .job_valid (job_valid),
    .job_head  (job_head),
    .job_take  (job_take),
    .empty     (empty),
    .pop       (pop),
    .out_word  (out_word)
  );

endmodule

// ===== dv/tb_stereo_biquad_peaking_eq.sv =====
// Self-checking testbench for the stereo biquad peaking equalizer.
module tb_stereo_biquad_peaking_eq;
  timeunit 1ns;
  timeprecision 1ps;

  import sbpe_pkg::*;

  // Run length guard; the run fails if the clock count reaches it.
  localparam int CYCLE_LIMIT = 500000;
  // Register indexes past coef_a2 exist on the port but hold nothing.
  localparam cfg_idx_t REG_SPARE_FIRST = cfg_idx_t'(REG_COEF_A2 + 1);

  typedef enum bit {ROW_SAMPLE, ROW_WRITE} row_kind_e;
  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_ALTERNATE} stall_mode_e;

  // One line of the directed table: either a register write or a sample word,
  // optionally with its result written out by hand.
  typedef struct {
    row_kind_e kind;
    cfg_idx_t  idx;
    coef_t     data;
    in_word_t  word;
    bit        typed;
    out_word_t want;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      push = 1'b0;
  logic      full;
  in_word_t  in_word = '0;
  logic      empty;
  logic      pop = 1'b0;
  out_word_t out_word;
  logic      cfg_write = 1'b0;
  cfg_idx_t  cfg_index = '0;
  coef_t     cfg_data = '0;

  // Filter state the testbench keeps for itself.
  coef_set_t coefs;
  sample_t   x_past1 [NUM_CHANNELS];
  sample_t   x_past2 [NUM_CHANNELS];
  sample_t   y_past1 [NUM_CHANNELS];
  sample_t   y_past2 [NUM_CHANNELS];

  out_word_t pending_results[$];
  dir_row_t  dir_table[$];
  int        mismatches = 0;
  int        results_seen = 0;
  int        cycle_count = 0;

  stereo_biquad_peaking_eq dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_word   (in_word),
    .empty     (empty),
    .pop       (pop),
    .out_word  (out_word),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Compute one filtered word and advance the channel's history.
  // The sum of five 56-bit products plus the bias fits easily in 64 bits.
  function automatic out_word_t biquad_next(in_word_t w);
    ch_idx_t   hi;
    longint    acc;
    longint    y;
    out_word_t r;
    // a channel number past the last one shares the last channel's history
    hi = (w.channel < NUM_CHANNELS) ? ch_idx_t'(w.channel) : ch_idx_t'(NUM_CHANNELS - 1);
    acc = longint'($signed(coefs.b0)) * longint'($signed(w.sample_in))
        + longint'($signed(coefs.b1)) * longint'(x_past1[hi])
        + longint'($signed(coefs.b2)) * longint'(x_past2[hi])
        - longint'($signed(coefs.a1)) * longint'(y_past1[hi])
        - longint'($signed(coefs.a2)) * longint'(y_past2[hi])
        + longint'(ROUND_BIAS);
    // arithmetic shift floors, so ties land toward positive infinity
    y = acc >>> COEF_FRAC_BITS;
    r.clipped = 1'b0;
    if (y > longint'(SAMPLE_MAX)) begin
      y = longint'(SAMPLE_MAX);
      r.clipped = 1'b1;
    end else if (y < longint'(SAMPLE_MIN)) begin
      y = longint'(SAMPLE_MIN);
      r.clipped = 1'b1;
    end
    r.channel_out = w.channel;
    r.sample_out  = sample_t'(y);
    // the saturated value, not the raw sum, goes into output history
    x_past2[hi] = x_past1[hi];
    x_past1[hi] = w.sample_in;
    y_past2[hi] = y_past1[hi];
    y_past1[hi] = r.sample_out;
    return r;
  endfunction

  function automatic dir_row_t wrow(cfg_idx_t idx, coef_t d);
    dir_row_t r;
    r = '{ROW_WRITE, idx, d, '0, 1'b0, '0};
    return r;
  endfunction

  // Sample row checked against the predictor.
  function automatic dir_row_t srow(logic ch, sample_t s);
    dir_row_t r;
    r = '{ROW_SAMPLE, REG_COEF_B0, '0, in_word_t'{ch, s}, 1'b0, '0};
    return r;
  endfunction

  // Sample row whose result is written out by hand.
  function automatic dir_row_t trow(logic ch, sample_t s, sample_t want_s, logic want_clip);
    dir_row_t r;
    r = '{ROW_SAMPLE, REG_COEF_B0, '0, in_word_t'{ch, s}, 1'b1,
          out_word_t'{ch, want_s, want_clip}};
    return r;
  endfunction

  // Draw one coefficient. Wild draws hit the register extremes and arbitrary
  // bit patterns; tame draws keep the loop roughly stable so that the output
  // history carries real values instead of sitting at full scale.
  function automatic coef_t pick_coef(cfg_idx_t idx, bit wild);
    int m;
    if (wild) begin
      case ($urandom_range(0, 5))
        0:       return coef_t'(32'h7FFF_FFFF);
        1:       return coef_t'(32'h8000_0000);
        2:       return '0;
        3:       return COEF_ONE;
        4:       return coef_t'(int'($urandom_range(0, 32'h1000_0000)) - 32'sh0800_0000);
        default: return coef_t'($urandom);
      endcase
    end
    case (idx)
      REG_COEF_A1: m = 255013683;   // about 1.9
      REG_COEF_A2: m = 127506841;   // about 0.95
      default:     m = 67108864;    // 0.5
    endcase
    return coef_t'(int'($urandom_range(0, 2 * m)) - m);
  endfunction

  task automatic note_fail(string what);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s", $time, what);
  endtask

  // Offer one word from the falling edge and hold it until the block takes it.
  task automatic send_word(in_word_t w, bit typed, out_word_t typed_want);
    out_word_t predicted;
    @(negedge clk);
    push    <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (full) @(posedge clk);
    predicted = biquad_next(w);
    pending_results.push_back(typed ? typed_want : predicted);
  endtask

  task automatic idle_input(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      push <= 1'b0;
    end
  endtask

  // Drop push and hold until every outstanding word has come back.
  task automatic drain();
    idle_input(1);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Only called with the block idle; mirror the write into the predictor.
  task automatic write_coef(cfg_idx_t idx, coef_t d);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_COEF_B0: coefs.b0 = d;
      REG_COEF_B1: coefs.b1 = d;
      REG_COEF_B2: coefs.b2 = d;
      REG_COEF_A1: coefs.a1 = d;
      REG_COEF_A2: coefs.a2 = d;
      default: ;  // spare index: the block drops it
    endcase
  endtask

  // Check each popped word against the oldest expectation.
  always @(posedge clk) begin
    out_word_t want;
    if (!rst && pop && !empty) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        note_fail($sformatf("unexpected word ch=%0d s=%0d clip=%0d",
                            out_word.channel_out, out_word.sample_out, out_word.clipped));
      end else begin
        want = pending_results.pop_front();
        if (out_word.channel_out !== want.channel_out ||
            out_word.sample_out !== want.sample_out ||
            out_word.clipped !== want.clipped)
          note_fail($sformatf("mismatch: want ch=%0d s=%0d clip=%0d, got ch=%0d s=%0d clip=%0d",
                              want.channel_out, want.sample_out, want.clipped,
                              out_word.channel_out, out_word.sample_out, out_word.clipped));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result side: switch between randomly chosen stall patterns, and
  // once, with words in flight, hold pop low long enough to back the block up
  // into its input queue.
  initial begin
    stall_mode_e mode;
    int          mode_left;
    int          hold_left;
    bit          long_hold_done;
    mode = STALL_NONE;
    mode_left = 0;
    hold_left = 0;
    long_hold_done = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        mode = stall_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(40, 120);
      end
      mode_left--;
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else if (!long_hold_done && results_seen >= 400 && pending_results.size() >= 2) begin
        pop <= 1'b0;
        hold_left = 300;
        long_hold_done = 1'b1;
      end else begin
        case (mode)
          STALL_NONE:      pop <= 1'b1;
          STALL_LIGHT:     pop <= ($urandom_range(0, 3) != 0);
          STALL_HEAVY:     pop <= ($urandom_range(0, 3) == 0);
          STALL_ALTERNATE: pop <= ~pop;
        endcase
      end
    end
  end

  // Input side: directed table first, then random phases.
  initial begin
    in_word_t w;
    int       n;
    int       burst_left;
    bit       wild;
    bit       gapless;

    coefs    = '0;
    coefs.b0 = COEF_ONE;
    foreach (x_past1[c]) begin
      x_past1[c] = '0;
      x_past2[c] = '0;
      y_past1[c] = '0;
      y_past2[c] = '0;
    end

    // Out of reset the section is a wire: b0 = 1.0, everything else zero.
    dir_table.push_back(trow(1'b0, SAMPLE_MAX, SAMPLE_MAX, 1'b0));
    dir_table.push_back(trow(1'b1, SAMPLE_MIN, SAMPLE_MIN, 1'b0));
    dir_table.push_back(trow(1'b0, sample_t'(0), sample_t'(0), 1'b0));
    dir_table.push_back(trow(1'b1, sample_t'(1), sample_t'(1), 1'b0));
    // Largest positive gain: full-scale input saturates both ways.
    dir_table.push_back(wrow(REG_COEF_B0, coef_t'(32'h7FFF_FFFF)));
    dir_table.push_back(trow(1'b0, SAMPLE_MAX, SAMPLE_MAX, 1'b1));
    dir_table.push_back(trow(1'b1, SAMPLE_MIN, SAMPLE_MIN, 1'b1));
    dir_table.push_back(srow(1'b0, sample_t'(-1)));
    dir_table.push_back(trow(1'b1, sample_t'(0), sample_t'(0), 1'b0));
    // Most negative gain flips the sign and saturates the other way.
    dir_table.push_back(wrow(REG_COEF_B0, coef_t'(32'h8000_0000)));
    dir_table.push_back(trow(1'b0, SAMPLE_MIN, SAMPLE_MAX, 1'b1));
    dir_table.push_back(trow(1'b1, SAMPLE_MAX, SAMPLE_MIN, 1'b1));
    // Half gain puts odd inputs exactly on a rounding tie; ties go up.
    dir_table.push_back(wrow(REG_COEF_B0, coef_t'(COEF_ONE >>> 1)));
    dir_table.push_back(trow(1'b0, sample_t'(1), sample_t'(1), 1'b0));
    dir_table.push_back(trow(1'b1, sample_t'(-1), sample_t'(0), 1'b0));
    dir_table.push_back(trow(1'b0, sample_t'(-3), sample_t'(-1), 1'b0));
    dir_table.push_back(trow(1'b1, sample_t'(3), sample_t'(2), 1'b0));
    // Load the remaining four taps, extremes on the feedback side, then hit the
    // spare indexes with patterns that would wreck the result if kept.
    dir_table.push_back(wrow(REG_COEF_B1, COEF_ONE));
    dir_table.push_back(wrow(REG_COEF_B2, coef_t'(-COEF_ONE)));
    dir_table.push_back(wrow(REG_COEF_A1, coef_t'(32'h7FFF_FFFF)));
    dir_table.push_back(wrow(REG_COEF_A2, coef_t'(32'h8000_0000)));
    dir_table.push_back(wrow(REG_SPARE_FIRST, coef_t'(32'h8000_0000)));
    dir_table.push_back(wrow(cfg_idx_t'(REG_SPARE_FIRST + 1), coef_t'(32'hFFFF_FFFF)));
    dir_table.push_back(wrow(cfg_idx_t'(REG_SPARE_FIRST + 2), coef_t'(32'h5A5A_A5A5)));
    dir_table.push_back(srow(1'b0, SAMPLE_MAX));
    dir_table.push_back(srow(1'b1, SAMPLE_MIN));
    dir_table.push_back(srow(1'b0, sample_t'(123456)));
    dir_table.push_back(srow(1'b1, sample_t'(-654321)));
    dir_table.push_back(srow(1'b0, SAMPLE_MIN));
    dir_table.push_back(srow(1'b1, SAMPLE_MAX));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Registers only change with nothing in flight, so drain before each write.
    foreach (dir_table[i]) begin
      if (dir_table[i].kind == ROW_WRITE) begin
        drain();
        write_coef(dir_table[i].idx, dir_table[i].data);
      end else begin
        send_word(dir_table[i].word, dir_table[i].typed, dir_table[i].want);
      end
    end

    // Random phases: reload all five taps, then stream words in bursts.
    // Every fourth phase streams with no input gaps at all.
    burst_left = 0;
    for (int phase = 0; phase < 12; phase++) begin
      drain();
      wild = (phase % 3 == 1);
      write_coef(REG_COEF_B0, pick_coef(REG_COEF_B0, wild));
      write_coef(REG_COEF_B1, pick_coef(REG_COEF_B1, wild));
      write_coef(REG_COEF_B2, pick_coef(REG_COEF_B2, wild));
      write_coef(REG_COEF_A1, pick_coef(REG_COEF_A1, wild));
      write_coef(REG_COEF_A2, pick_coef(REG_COEF_A2, wild));
      if ($urandom_range(0, 2) == 0)
        write_coef(cfg_idx_t'($urandom_range(REG_SPARE_FIRST, (1 << CFG_IDX_BITS) - 1)),
                   coef_t'($urandom));
      gapless = (phase % 4 == 3);
      n = $urandom_range(85, 105);
      repeat (n) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          if (!gapless && $urandom_range(0, 3) != 0)
            idle_input($urandom_range(1, 12));
        end
        burst_left--;
        w.channel = $urandom_range(0, 1);
        case ($urandom_range(0, 19))
          0:       w.sample_in = SAMPLE_MAX;
          1:       w.sample_in = SAMPLE_MIN;
          2:       w.sample_in = '0;
          3:       w.sample_in = sample_t'(-1);
          4, 5, 6: w.sample_in = sample_t'(int'($urandom_range(0, 2000)) - 1000);
          default: w.sample_in = sample_t'($urandom);
        endcase
        send_word(w, 1'b0, '0);
      end
    end

    // Wait out the last words, then give any stray word time to show up.
    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/sbpe_pkg.sv
rtl/core/sbpe_coefs.sv
rtl/core/sbpe_front.sv
rtl/core/sbpe_back.sv
rtl/core/stereo_biquad_peaking_eq.sv
dv/tb_stereo_biquad_peaking_eq.sv
